@@ rtl/arh_pkg.sv @@
// ----------------------------------------------------------------------------
// arh_pkg
// Shared types and codes for the auto-ranging histogram: opcodes, memory
// port selects and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package arh_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RS_INPUT   = 2'd0;
  localparam rd_sel_t RS_V       = 2'd1;
  localparam rd_sel_t RS_PAIR_LO = 2'd2;
  localparam rd_sel_t RS_PAIR_HI = 2'd3;

  typedef logic [1:0] wr_sel_t;
  localparam wr_sel_t WS_ADD   = 2'd0;
  localparam wr_sel_t WS_MERGE = 2'd1;
  localparam wr_sel_t WS_COPY  = 2'd2;
  localparam wr_sel_t WS_ZERO  = 2'd3;

  typedef struct packed {
    logic    cap;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    latch_a;
    logic    grow;
    logic    emit;
  } arh_cmd_t;

  typedef struct packed {
    logic op_rd;
    logic neg;
    logic in_range;
    logic v_big;
    logic pair_last;
    logic ptr_last;
    logic slot_free;
  } arh_sts_t;

endpackage

@@ rtl/arh_if.sv @@
// ----------------------------------------------------------------------------
// arh_in_if / arh_out_if
// Valid/ready channels carrying the histogram requests and results.
// ----------------------------------------------------------------------------
interface arh_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] sample;
  logic [7:0]  read_bin;

  modport source (output valid, opcode, sample, read_bin, input ready);
  modport sink   (input valid, opcode, sample, read_bin, output ready);
endinterface

interface arh_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin_index;
  logic [31:0] bin_count;
  logic [4:0]  width_shift;
  logic [31:0] total_count;
  logic        rejected;

  modport source (output valid, bin_index, bin_count, width_shift, total_count, rejected,
                  input ready);
  modport sink   (input valid, bin_index, bin_count, width_shift, total_count, rejected,
                  output ready);
endinterface

@@ rtl/arh_ram.sv @@
// ----------------------------------------------------------------------------
// arh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/arh_ctrl.sv @@
// ----------------------------------------------------------------------------
// arh_ctrl
// Sequencer: reset clear, accept/check, merge passes and result emission.
// ----------------------------------------------------------------------------
module arh_ctrl #(
  parameter int BIN_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  arh_pkg::arh_sts_t sts,
  output arh_pkg::arh_cmd_t cmd
);

  localparam logic ODD = (BIN_COUNT % 2) != 0;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_M_RD0    = 4'd3;
  localparam logic [3:0] S_M_RD1    = 4'd4;
  localparam logic [3:0] S_M_WR     = 4'd5;
  localparam logic [3:0] S_M_ODD_RD = 4'd6;
  localparam logic [3:0] S_M_ODD_WR = 4'd7;
  localparam logic [3:0] S_M_CLR    = 4'd8;
  localparam logic [3:0] S_RELOAD   = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = arh_pkg::WS_ZERO;
        cmd.ptr_inc = 1'b1;
        if (sts.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = arh_pkg::RS_INPUT;
        cmd.cap    = in_valid;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.op_rd || sts.neg) begin
          if (sts.slot_free) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (sts.v_big) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = S_M_RD0;
        end else if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = arh_pkg::WS_ADD;
          state_nxt  = S_IDLE;
        end
      end
      S_M_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = arh_pkg::RS_PAIR_LO;
        state_nxt  = S_M_RD1;
      end
      S_M_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = arh_pkg::RS_PAIR_HI;
        cmd.latch_a = 1'b1;
        state_nxt   = S_M_WR;
      end
      S_M_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = arh_pkg::WS_MERGE;
        cmd.ptr_inc = 1'b1;
        if (!sts.pair_last) state_nxt = S_M_RD0;
        else if (ODD)       state_nxt = S_M_ODD_RD;
        else                state_nxt = S_M_CLR;
      end
      S_M_ODD_RD: begin
        // ptr sits at BIN_COUNT/2 here, so the low pair address is the last bin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = arh_pkg::RS_PAIR_LO;
        state_nxt  = S_M_ODD_WR;
      end
      S_M_ODD_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = arh_pkg::WS_COPY;
        cmd.ptr_inc = 1'b1;
        state_nxt   = S_M_CLR;
      end
      S_M_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = arh_pkg::WS_ZERO;
        cmd.ptr_inc = 1'b1;
        if (sts.ptr_last) begin
          cmd.grow  = 1'b1;
          state_nxt = S_RELOAD;
        end
      end
      S_RELOAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = arh_pkg::RS_V;
        state_nxt  = S_CHECK;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

@@ rtl/arh_dp.sv @@
// ----------------------------------------------------------------------------
// arh_dp
// Datapath: item capture, bin index shift, saturating adders, merge pointer,
// exponent and total registers, memory port muxing and result register.
// ----------------------------------------------------------------------------
module arh_dp #(
  parameter int BIN_COUNT = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  arh_pkg::arh_cmd_t            cmd,
  output arh_pkg::arh_sts_t            sts,
  input  logic                         in_opcode,
  input  logic [31:0]                  in_sample,
  input  logic [7:0]                   in_read_bin,
  output logic                         ram_we,
  output logic [$clog2(BIN_COUNT)-1:0] ram_waddr,
  output logic [31:0]                  ram_wdata,
  output logic                         ram_re,
  output logic [$clog2(BIN_COUNT)-1:0] ram_raddr,
  input  logic [31:0]                  ram_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_bin_index,
  output logic [31:0]                  out_bin_count,
  output logic [4:0]                   out_width_shift,
  output logic [31:0]                  out_total_count,
  output logic                         out_rejected
);

  localparam int          AW    = $clog2(BIN_COUNT);
  localparam int          HALF  = BIN_COUNT / 2;
  localparam logic [30:0] NBINS = 31'(BIN_COUNT);
  localparam logic [31:0] NB32  = 32'(BIN_COUNT);

  logic          op_r, neg_r;
  logic [7:0]    rbin_r;
  logic [30:0]   v_r;
  logic [AW-1:0] ptr_r;
  logic [31:0]   a_r;
  logic [4:0]    exp_r;
  logic [31:0]   total_r, total_nxt;
  logic          out_valid_r;
  logic [7:0]    idx_r;
  logic [31:0]   cnt_r, tot_out_r;
  logic [4:0]    shift_r;
  logic          rej_r;

  logic [30:0]   shifted;
  logic [AW-1:0] v_idx;
  logic [31:0]   bin_inc;
  logic [32:0]   pair_sum;
  logic [31:0]   pair_sat;
  logic          is_add;

  assign shifted  = in_sample[30:0] >> exp_r;
  assign v_idx    = AW'(v_r);
  assign bin_inc  = (ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1;
  assign pair_sum = {1'b0, a_r} + {1'b0, ram_rdata};
  assign pair_sat = pair_sum[32] ? '1 : pair_sum[31:0];
  assign is_add   = (op_r == arh_pkg::OP_ADD) && !neg_r;
  assign total_nxt = (is_add && total_r != '1) ? total_r + 32'd1 : total_r;

  assign sts.op_rd     = op_r == arh_pkg::OP_READ;
  assign sts.neg       = neg_r;
  assign sts.in_range  = {24'd0, rbin_r} < NB32;
  assign sts.v_big     = v_r >= NBINS;
  assign sts.pair_last = ptr_r == AW'(HALF - 1);
  assign sts.ptr_last  = ptr_r == AW'(BIN_COUNT - 1);
  assign sts.slot_free = !out_valid_r || out_ready;

  assign ram_re = cmd.rd_en;
  assign ram_we = cmd.wr_en;

  always_comb begin
    unique case (cmd.rd_sel)
      arh_pkg::RS_INPUT:   ram_raddr = (in_opcode == arh_pkg::OP_READ) ? AW'(in_read_bin)
                                                                      : AW'(shifted);
      arh_pkg::RS_V:       ram_raddr = v_idx;
      arh_pkg::RS_PAIR_LO: ram_raddr = AW'({ptr_r, 1'b0});
      arh_pkg::RS_PAIR_HI: ram_raddr = AW'({ptr_r, 1'b1});
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      arh_pkg::WS_ADD: begin
        ram_waddr = v_idx;
        ram_wdata = bin_inc;
      end
      arh_pkg::WS_MERGE: begin
        ram_waddr = ptr_r;
        ram_wdata = pair_sat;
      end
      arh_pkg::WS_COPY: begin
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
      end
      arh_pkg::WS_ZERO: begin
        ram_waddr = ptr_r;
        ram_wdata = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      exp_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ptr_clr)      ptr_r <= '0;
      else if (cmd.ptr_inc) ptr_r <= ptr_r + AW'(1);
      if (cmd.grow) exp_r <= exp_r + 5'd1;
      if (cmd.emit) total_r <= total_nxt;
      if (cmd.emit)         out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_opcode;
      neg_r  <= in_sample[31];
      rbin_r <= in_read_bin;
      v_r    <= shifted;
    end else if (cmd.grow) begin
      v_r <= v_r >> 1;
    end
    if (cmd.latch_a) a_r <= ram_rdata;
    if (cmd.emit) begin
      shift_r   <= exp_r;
      tot_out_r <= total_nxt;
      rej_r     <= 1'b0;
      priority if (op_r == arh_pkg::OP_READ) begin
        idx_r <= rbin_r;
        cnt_r <= sts.in_range ? ram_rdata : '0;
      end else if (neg_r) begin
        idx_r <= '0;
        cnt_r <= '0;
        rej_r <= 1'b1;
      end else begin
        idx_r <= 8'(v_idx);
        cnt_r <= bin_inc;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_index   = idx_r;
  assign out_bin_count   = cnt_r;
  assign out_width_shift = shift_r;
  assign out_total_count = tot_out_r;
  assign out_rejected    = rej_r;

endmodule

@@ rtl/auto_ranging_histogram.sv @@
// ----------------------------------------------------------------------------
// auto_ranging_histogram
// Histogram of BIN_COUNT bins with power-of-two bin width that doubles
// (merging bin pairs) whenever a sample falls beyond the last bin.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake      | beat contents
//   in_item  | in  | valid / ready  | opcode, sample, read_bin
//   out_item | out | valid / ready  | bin_index, bin_count, width_shift,
//            |     |                | total_count, rejected
//
// Add, read and rejected add: accept with bin read, then check/update; the
// bin memory read-modify-write needs both steps.
// Each exponent step walks the bin memory: it sums each bin pair (saturating),
// copies an odd last bin, clears the upper bins and rereads the sample's bin.
// After reset the bins are cleared with in_item.ready low.
// A stalled result holds the block in its check step until out_item takes it.
// ----------------------------------------------------------------------------
module auto_ranging_histogram #(
  parameter int BIN_COUNT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  arh_in_if.sink           in_item,
  arh_out_if.source        out_item
);

  localparam int AW = $clog2(BIN_COUNT);

  arh_pkg::arh_cmd_t cmd;
  arh_pkg::arh_sts_t sts;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  arh_ctrl #(.BIN_COUNT(BIN_COUNT)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arh_dp #(.BIN_COUNT(BIN_COUNT)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_item.opcode),
    .in_sample       (in_item.sample),
    .in_read_bin     (in_item.read_bin),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_item.valid),
    .out_ready       (out_item.ready),
    .out_bin_index   (out_item.bin_index),
    .out_bin_count   (out_item.bin_count),
    .out_width_shift (out_item.width_shift),
    .out_total_count (out_item.total_count),
    .out_rejected    (out_item.rejected)
  );

  arh_ram #(.WIDTH(32), .DEPTH(BIN_COUNT)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ rtl/arh_chk.sv @@
// ----------------------------------------------------------------------------
// arh_chk
// Port-level checks for the auto-ranging histogram, bound to the top level.
// ----------------------------------------------------------------------------
module arh_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_bin_index,
  input logic [31:0] out_bin_count,
  input logic [4:0]  out_width_shift,
  input logic [31:0] out_total_count,
  input logic        out_rejected
);

  logic        seen_r;
  logic [4:0]  last_shift_r;
  logic [31:0] last_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      last_shift_r <= '0;
      last_total_r <= '0;
    end else if (out_valid && out_ready) begin
      seen_r       <= 1'b1;
      last_shift_r <= out_width_shift;
      last_total_r <= out_total_count;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_count)
                                && $stable(out_total_count) && $stable(out_bin_index))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_bin_index == 8'd0 && out_bin_count == 32'd0)
    else $error("rejected beat carries a bin");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && seen_r |-> out_total_count >= last_total_r)
    else $error("total count went down");

  a_shift_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && seen_r |-> out_width_shift >= last_shift_r)
    else $error("bin width shrank");

endmodule

bind auto_ranging_histogram arh_chk u_arh_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_item.valid),
  .out_ready       (out_item.ready),
  .out_bin_index   (out_item.bin_index),
  .out_bin_count   (out_item.bin_count),
  .out_width_shift (out_item.width_shift),
  .out_total_count (out_item.total_count),
  .out_rejected    (out_item.rejected)
);
